// ----- rtl/gcdl_pkg.sv -----
package gcdl_pkg;

  localparam int DIVISOR_WIDTH = 32;
  localparam int MULTIPLE_WIDTH = 64;
  localparam int DEFAULT_OPERAND_WIDTH = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_MUL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic mul_init;
    logic mul_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic zero_case;
    logic gcd_done;
    logic cnt_last;
  } status_t;

endpackage

// ----- rtl/gcdl_if.sv -----
interface gcdl_in_if;
  logic                                valid;
  logic                                ready;
  logic [gcdl_pkg::DIVISOR_WIDTH-1:0]  operand_a;
  logic [gcdl_pkg::DIVISOR_WIDTH-1:0]  operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink (input valid, input operand_a, input operand_b, output ready);
endinterface

interface gcdl_out_if;
  logic                                valid;
  logic                                ready;
  logic [gcdl_pkg::DIVISOR_WIDTH-1:0]  divisor;
  logic [gcdl_pkg::MULTIPLE_WIDTH-1:0] multiple;

  modport source (output valid, output divisor, output multiple, input ready);
  modport sink (input valid, input divisor, input multiple, output ready);
endinterface

// ----- rtl/gcd_and_lcm_unit.sv -----
// channel  dir  payload                          handshake
// in_ch    in   operand_a[31:0], operand_b[31:0]  valid/ready
// out_ch   out  divisor[31:0], multiple[63:0]     valid/ready
//
// One word at a time: a load, binary-gcd steps until both values match,
// OPERAND_WIDTH restoring divide steps and OPERAND_WIDTH shift-add multiply
// steps, then a load into the output register; when an operand is 0 the
// gcd, divide and multiply steps are skipped.
// A held result does not block the next input word; the block stalls only
// at the end of a word until the output register is free. Synchronous reset.
module gcd_and_lcm_unit #(
  parameter int OPERAND_WIDTH = gcdl_pkg::DEFAULT_OPERAND_WIDTH
) (
  input logic        clk,
  input logic        rst,
  gcdl_in_if.sink    in_ch,
  gcdl_out_if.source out_ch
);

  gcdl_pkg::cmd_t    cmd;
  gcdl_pkg::status_t status;

  gcdl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  gcdl_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk       (clk),
    .operand_a (in_ch.operand_a),
    .operand_b (in_ch.operand_b),
    .cmd       (cmd),
    .status    (status),
    .divisor   (out_ch.divisor),
    .multiple  (out_ch.multiple)
  );

endmodule

// ----- rtl/gcdl_ctrl.sv -----
module gcdl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  gcdl_pkg::status_t status,
  output gcdl_pkg::cmd_t    cmd
);

  gcdl_pkg::state_t state;
  gcdl_pkg::state_t state_next;
  logic             out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      gcdl_pkg::ST_IDLE: begin
        if (in_valid) state_next = gcdl_pkg::ST_GCD;
      end
      gcdl_pkg::ST_GCD: begin
        if (status.zero_case) state_next = gcdl_pkg::ST_FINISH;
        else if (status.gcd_done) state_next = gcdl_pkg::ST_DIV;
      end
      gcdl_pkg::ST_DIV: begin
        if (status.cnt_last) state_next = gcdl_pkg::ST_MUL;
      end
      gcdl_pkg::ST_MUL: begin
        if (status.cnt_last) state_next = gcdl_pkg::ST_FINISH;
      end
      gcdl_pkg::ST_FINISH: begin
        if (out_free) state_next = gcdl_pkg::ST_IDLE;
      end
      default: state_next = gcdl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      gcdl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      gcdl_pkg::ST_GCD: begin
        cmd.gcd_step = !status.zero_case && !status.gcd_done;
        cmd.div_init = !status.zero_case && status.gcd_done;
      end
      gcdl_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.mul_init = status.cnt_last;
      end
      gcdl_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
      end
      gcdl_pkg::ST_FINISH: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gcdl_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/gcdl_dp.sv -----
module gcdl_dp #(
  parameter int OPERAND_WIDTH = gcdl_pkg::DEFAULT_OPERAND_WIDTH
) (
  input  logic                                clk,
  input  logic [gcdl_pkg::DIVISOR_WIDTH-1:0]  operand_a,
  input  logic [gcdl_pkg::DIVISOR_WIDTH-1:0]  operand_b,
  input  gcdl_pkg::cmd_t                      cmd,
  output gcdl_pkg::status_t                   status,
  output logic [gcdl_pkg::DIVISOR_WIDTH-1:0]  divisor,
  output logic [gcdl_pkg::MULTIPLE_WIDTH-1:0] multiple
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W);

  logic [W-1:0]  opb;
  logic [W-1:0]  u;
  logic [W-1:0]  v;
  logic [CW-1:0] k;
  logic [W-1:0]  g;
  logic [W-1:0]  rem;
  logic [W-1:0]  q;
  logic [W-1:0]  hi;
  logic [CW-1:0] cnt;
  logic          zero;

  logic [W:0]    trial;
  logic          fits;
  logic [W:0]    acc;
  logic [W-1:0]  a_in;
  logic [W-1:0]  b_in;

  assign a_in  = operand_a[W-1:0];
  assign b_in  = operand_b[W-1:0];
  assign trial = {rem, q[W-1]};
  assign fits  = trial >= {1'b0, g};
  assign acc   = {1'b0, hi} + (q[0] ? {1'b0, opb} : '0);

  assign status.zero_case = zero;
  assign status.gcd_done  = (u == v);
  assign status.cnt_last  = (cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u    <= a_in;
      v    <= b_in;
      q    <= a_in;
      opb  <= b_in;
      k    <= '0;
      zero <= (a_in == '0) || (b_in == '0);
    end else if (cmd.gcd_step) begin
      // binary gcd: strip common twos, halve the even one, then odd-odd subtract
      if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + CW'(1);
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u > v) begin
        u <= u - v;
      end else begin
        v <= v - u;
      end
    end

    if (cmd.div_init) begin
      g   <= u << k;
      rem <= '0;
      cnt <= CW'(W - 1);
    end else if (cmd.div_step || cmd.mul_step) begin
      cnt <= (cnt == '0) ? CW'(W - 1) : cnt - CW'(1);
    end

    if (cmd.div_step) begin
      rem <= fits ? W'(trial - {1'b0, g}) : trial[W-1:0];
      q   <= {q[W-2:0], fits};
    end else if (cmd.mul_step) begin
      hi <= acc[W:1];
      q  <= {acc[0], q[W-1:1]};
    end

    if (cmd.mul_init) hi <= '0;

    if (cmd.out_load) begin
      divisor  <= zero ? gcdl_pkg::DIVISOR_WIDTH'(u + v) : gcdl_pkg::DIVISOR_WIDTH'(g);
      multiple <= zero ? '0 : gcdl_pkg::MULTIPLE_WIDTH'({hi, q});
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int OP_W = gcdl_pkg::DEFAULT_OPERAND_WIDTH;
  localparam int STALL_LIMIT = 6000;
  localparam int HOLD_CYCLES = 1500;
  localparam int HOLD_AFTER = 300;
  localparam int RANDOM_WORDS = 1280;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [gcdl_pkg::DIVISOR_WIDTH-1:0] operand_a;
    logic [gcdl_pkg::DIVISOR_WIDTH-1:0] operand_b;
  } operand_pair_t;

  typedef struct packed {
    logic [gcdl_pkg::DIVISOR_WIDTH-1:0]  divisor;
    logic [gcdl_pkg::MULTIPLE_WIDTH-1:0] multiple;
  } gcd_lcm_t;

  logic clk;
  logic rst;

  gcdl_in_if  operands_ch ();
  gcdl_out_if results_ch ();

  gcd_and_lcm_unit #(
    .OPERAND_WIDTH(OP_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(operands_ch.sink),
    .out_ch(results_ch.source)
  );

  operand_pair_t operand_words[$];
  gcd_lcm_t      predicted_results[$];
  int            total_words;
  int            words_in;
  int            results_seen;
  int            mismatches;
  logic          word_taken;

  function automatic gcd_lcm_t gcd_lcm_of(operand_pair_t w);
    logic [63:0] msk;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] a0;
    logic [63:0] b0;
    logic [63:0] r;
    gcd_lcm_t    res;
    msk = (64'd1 << OP_W) - 64'd1;
    x = {32'd0, w.operand_a} & msk;
    y = {32'd0, w.operand_b} & msk;
    a0 = x;
    b0 = y;
    if (x == 64'd0 || y == 64'd0) begin
      res.divisor = gcdl_pkg::DIVISOR_WIDTH'(x + y);
      res.multiple = '0;
    end else begin
      while (y != 64'd0) begin
        r = x % y;
        x = y;
        y = r;
      end
      res.divisor = x[gcdl_pkg::DIVISOR_WIDTH-1:0];
      res.multiple = (a0 / x) * b0;
    end
    return res;
  endfunction

  function automatic logic [31:0] low_bits(int n);
    return (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
  endfunction

  function automatic operand_pair_t random_pair();
    operand_pair_t w;
    int            pick;
    int            gb;
    logic [31:0]   g;
    pick = $urandom_range(0, 99);
    w.operand_a = $urandom;
    w.operand_b = $urandom;
    if (pick < 30) begin
      // plain random
    end else if (pick < 60) begin
      // shared factor, products kept within 32 bits
      gb = $urandom_range(1, 24);
      g = $urandom & low_bits(gb);
      if (g == 32'd0) g = 32'd1;
      w.operand_a = g * ($urandom & low_bits(32 - gb));
      w.operand_b = g * ($urandom & low_bits(32 - gb));
    end else if (pick < 70) begin
      w.operand_a = $urandom_range(0, 15);
      w.operand_b = $urandom_range(0, 15);
    end else if (pick < 78) begin
      case ($urandom_range(0, 4))
        0, 1: w.operand_a = '0;
        2, 3: w.operand_b = '0;
        default: begin
          w.operand_a = '0;
          w.operand_b = '0;
        end
      endcase
    end else if (pick < 88) begin
      gb = $urandom_range(0, 31);
      w.operand_a = $urandom >> gb;
      if ($urandom_range(0, 1)) w.operand_b = w.operand_a;
      else w.operand_b = w.operand_a * $urandom_range(1, 1 << gb);
      if ($urandom_range(0, 1)) w = {w.operand_b, w.operand_a};
    end else begin
      w.operand_a = 32'd1 << $urandom_range(0, 31);
      w.operand_b = $urandom << $urandom_range(0, 31);
    end
    return w;
  endfunction

  function automatic int sender_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("%0t result %0d %s: got %0h want %0h", $realtime, results_seen, what, got, want);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // stimulus and end of run
  initial begin
    operand_pair_t dir[$];
    dir = '{
      '{32'd0, 32'd0}, '{32'd0, 32'd7}, '{32'd9, 32'd0},
      '{32'd0, 32'hFFFF_FFFF}, '{32'hFFFF_FFFF, 32'd0},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF}, '{32'd1, 32'd1},
      '{32'd1, 32'hFFFF_FFFF}, '{32'hFFFF_FFFF, 32'd1},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFE}, '{32'hFFFF_FFFB, 32'hFFFF_FFEF},
      '{32'h8000_0000, 32'h8000_0000}, '{32'h8000_0000, 32'h0000_0001},
      '{32'h8000_0000, 32'h7FFF_FFFF}, '{32'd12, 32'd18},
      '{32'd18, 32'd12}, '{32'd7, 32'd7}, '{32'd1071, 32'd462},
      '{32'h5555_5555, 32'hAAAA_AAAA}, '{32'd3, 32'h8000_0000},
      '{32'd65536, 32'd4096}, '{32'hFFFF_0000, 32'h0000_FFFF}
    };
    foreach (dir[i]) operand_words.push_back(dir[i]);
    for (int i = 0; i < RANDOM_WORDS; i++) operand_words.push_back(random_pair());
    total_words = operand_words.size();

    do @(negedge clk);
    while (words_in != total_words || predicted_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("PASS gcd_and_lcm_unit");
    end else begin
      $display("FAIL gcd_and_lcm_unit");
    end
    $finish;
  end

  initial begin
    rst = 1'b1;
    operands_ch.valid = 1'b0;
    operands_ch.operand_a = '0;
    operands_ch.operand_b = '0;
    results_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // sender
  int  gap_left = 0;
  bit  send_burst = 1'b0;

  always @(negedge clk) begin
    operand_pair_t w;
    if (!rst) begin
      if (operands_ch.valid && !word_taken) begin
      end else if (gap_left > 0) begin
        operands_ch.valid <= 1'b0;
        gap_left = gap_left - 1;
      end else if (operand_words.size() != 0) begin
        w = operand_words.pop_front();
        operands_ch.valid <= 1'b1;
        operands_ch.operand_a <= w.operand_a;
        operands_ch.operand_b <= w.operand_b;
        if ($urandom_range(0, 149) == 0) send_burst = !send_burst;
        gap_left = sender_gap(send_burst);
      end else begin
        operands_ch.valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off to back the block up
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  recv_burst = 1'b0;

  always @(negedge clk) begin
    int r;
    if (!rst) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 999) == 0) recv_burst = !recv_burst;
      if (hold_left > 0) begin
        results_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        results_ch.ready <= 1'b0;
      end else if (recv_burst) begin
        results_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        results_ch.ready <= 1'b0;
        stall_left = stall_left - 1;
      end else if (r < 15) begin
        stall_left = (r < 2) ? $urandom_range(8, 60) : $urandom_range(0, 3);
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    operand_pair_t w;
    gcd_lcm_t      want;
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= operands_ch.valid && operands_ch.ready;
      if (operands_ch.valid && operands_ch.ready) begin
        w.operand_a = operands_ch.operand_a;
        w.operand_b = operands_ch.operand_b;
        predicted_results.push_back(gcd_lcm_of(w));
        words_in++;
      end
      if (results_ch.valid && results_ch.ready) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          report("unexpected word", {32'd0, results_ch.divisor}, 64'd0);
        end else begin
          want = predicted_results.pop_front();
          if (results_ch.divisor !== want.divisor)
            report("divisor", {32'd0, results_ch.divisor}, {32'd0, want.divisor});
          if (results_ch.multiple !== want.multiple)
            report("multiple", results_ch.multiple, want.multiple);
        end
      end
    end
  end

  // watchdog
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (operands_ch.valid && operands_ch.ready)
        || (results_ch.valid && results_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL gcd_and_lcm_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- sim.f -----
rtl/gcdl_pkg.sv
rtl/gcdl_if.sv
rtl/gcdl_ctrl.sv
rtl/gcdl_dp.sv
rtl/gcd_and_lcm_unit.sv
verif/testbench.sv
